// ----- rtl/tet_pkg.sv -----
package tet_pkg;

   // command codes carried on the input selector
   localparam int CMD_W = 3;
   localparam logic [CMD_W-1:0] CMD_ADD_CB   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADD_PIN  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_STOP_ONE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_STOP_ALL = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TICK     = 3'd4;

   // result kinds
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_DONE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIRE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PIN  = 2'd2;

   localparam int TIME_W  = 32;
   localparam int COUNT_W = 16;
   localparam int PIN_W   = 8;
   localparam int ID_W    = 5;

   localparam logic [COUNT_W-1:0] COUNT_FOREVER = '1;

   // limit on fires reported per tick, and the width of the counter that tracks them
   localparam int MAX_RESULTS = 16;
   localparam int NRES_W      = 5;

   // one table entry as kept in the slot memory
   typedef struct packed {
      logic               is_pin;
      logic [TIME_W-1:0]  start;
      logic [TIME_W-1:0]  interval;
      logic [COUNT_W-1:0] count;
      logic [PIN_W-1:0]   pin;
      logic               level;
   } slot_type;

   // input payload, last field in the lowest bits
   typedef struct packed {
      logic [1:0]         pad;
      logic [ID_W-1:0]    target_id;
      logic               start_level;
      logic [PIN_W-1:0]   pin;
      logic [COUNT_W-1:0] repeat_count;
      logic [TIME_W-1:0]  interval;
      logic [TIME_W-1:0]  now;
   } req_data_type;

   // result payload, last field in the lowest bits
   typedef struct packed {
      logic [1:0]       pad;
      logic             pin_level;
      logic [PIN_W-1:0] pin_res;
      logic [ID_W-1:0]  event_id;
   } rsp_data_type;

endpackage

// ----- rtl/tet_ram.sv -----
module tet_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/timed_event_table.sv -----
// timed event table: SLOTS timed events (id = slot + 1) driven one command transaction at
// a time. The selector in req_tuser picks add callback event, add pin event, stop one,
// stop all or tick; any other code just answers. Every command answers with at least one
// result transaction and flags its final one with rsp_tlast. An add takes the lowest free
// slot and answers with the id (0 when the table is full); a pin add answers with the
// toggled pin level. A tick walks slots in id order, answering with one result per due
// event with repeats left, MAX_RESULTS at most, or with one empty answer when none fired.
// Event fields live in a single-port-write, registered-read slot memory; the used and
// stopped marks are flip-flops, cleared at reset, so no clearing pass is needed. A tick
// does a first memory read, then one read-modify-write per slot with the next slot's read
// overlapped, then hands over the final result; the walk stalls while the result side
// holds off rsp_tready. An add scans the used marks one slot a cycle; stop and other
// commands answer with a single result. A new command is taken once the previous one has
// handed its last result to the output register.
module timed_event_table #(
   parameter int SLOTS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // command channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // now[31:0], interval[63:32], repeat_count[79:64], pin[87:80], start_level[88],
   // target_id[93:89], zero fill [95:94]
   input  tet_pkg::req_data_type            req_tdata,
   // cmd[2:0]
   input  logic [tet_pkg::CMD_W-1:0]        req_tuser,
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // event_id[4:0], pin_res[12:5], pin_level[13], zero fill [15:14]
   output tet_pkg::rsp_data_type            rsp_tdata,
   // result_kind[1:0]
   output logic [tet_pkg::KIND_W-1:0]       rsp_tuser,
   output logic                             rsp_tlast
);

   import tet_pkg::*;

   localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNTW = $clog2(SLOTS + 1);
   localparam logic [IDXW-1:0] LAST_IDX  = IDXW'(SLOTS - 1);
   localparam logic [CNTW-1:0] SLOTS_CNT = CNTW'(SLOTS);
   localparam logic [NRES_W-1:0] NRES_MAX = NRES_W'(MAX_RESULTS);
   localparam int ENT_W = $bits(slot_type);

   // sequencer states
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_ADD      = 3'd1;
   localparam logic [2:0] ST_TICK     = 3'd2;
   localparam logic [2:0] ST_TICK_END = 3'd3;
   localparam logic [2:0] ST_REPLY    = 3'd4;

   logic [2:0] state_ff, state_in;

   // captured command
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [TIME_W-1:0]  ivl_ff, ivl_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [PIN_W-1:0]   pin_ff, pin_in;
   logic               lvl_ff, lvl_in;

   // per-slot marks: used, and stopped (count reads as zero until the slot is rewritten)
   logic [SLOTS-1:0] used_ff, used_in;
   logic [SLOTS-1:0] stop_ff, stop_in;

   // add scan and tick walk
   logic [IDXW-1:0]   scan_idx_ff, scan_idx_in;
   logic [CNTW-1:0]   issue_idx_ff, issue_idx_in;   // next slot to read
   logic [IDXW-1:0]   cur_idx_ff, cur_idx_in;       // slot whose data sits on rd_data
   logic              cur_valid_ff, cur_valid_in;
   logic [NRES_W-1:0] nres_ff, nres_in;

   // a fire is held back one step so that the final one can carry tlast
   logic              hold_valid_ff, hold_valid_in;
   logic [KIND_W-1:0] hold_kind_ff, hold_kind_in;
   logic [ID_W-1:0]   hold_id_ff, hold_id_in;
   logic [PIN_W-1:0]  hold_pin_ff, hold_pin_in;
   logic              hold_lvl_ff, hold_lvl_in;

   // output register
   logic              rsp_valid_ff;
   logic [KIND_W-1:0] rsp_kind_ff;
   rsp_data_type      rsp_data_ff;
   logic              rsp_last_ff;

   logic              push;
   logic [KIND_W-1:0] push_kind;
   rsp_data_type      push_data;
   logic              push_last;

   // slot memory port
   logic             wr_en;
   logic [IDXW-1:0]  wr_addr;
   slot_type         wr_ent;
   logic             rd_en;
   logic [IDXW-1:0]  rd_addr;
   logic [ENT_W-1:0] rd_data;
   slot_type         ent;

   logic accept;
   logic out_ok;

   // tick evaluation of the current slot
   logic               used_cur;
   logic [COUNT_W-1:0] cnt_eff;
   logic [TIME_W-1:0]  elapsed;
   logic               due;
   logic               fire;
   logic               report;
   logic [COUNT_W-1:0] cnt_next;
   logic               lvl_next;
   logic               stall;
   logic               proceed;
   logic               issue;
   logic [ID_W-1:0]    cur_id;
   logic [ID_W-1:0]    scan_id;
   logic               scan_free;

   tet_ram #(
      .WIDTH (ENT_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign ent        = slot_type'(rd_data);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign out_ok     = !rsp_valid_ff || rsp_tready;

   assign cur_id  = ID_W'(32'(cur_idx_ff) + 32'd1);
   assign scan_id = ID_W'(32'(scan_idx_ff) + 32'd1);
   assign scan_free = !used_ff[scan_idx_ff];

   // due test uses the wrapped difference against the interval
   assign used_cur = used_ff[cur_idx_ff];
   assign cnt_eff  = stop_ff[cur_idx_ff] ? '0 : ent.count;
   assign elapsed  = now_ff - ent.start;
   assign due      = cur_valid_ff && used_cur && (elapsed >= ent.interval);
   assign fire     = due && (cnt_eff != '0);
   assign report   = fire && (nres_ff < NRES_MAX);
   assign cnt_next = (fire && (cnt_eff != COUNT_FOREVER)) ? cnt_eff - 1'b1 : cnt_eff;
   assign lvl_next = fire ? (ent.level ^ ent.is_pin) : ent.level;

   // a second fire needs the held one moved out first
   assign stall   = report && hold_valid_ff && !out_ok;
   assign proceed = (state_ff == ST_TICK) && cur_valid_ff && !stall;
   assign issue   = (state_ff == ST_TICK) && (!cur_valid_ff || proceed)
                    && (issue_idx_ff < SLOTS_CNT);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      now_in        = now_ff;
      ivl_in        = ivl_ff;
      cnt_in        = cnt_ff;
      pin_in        = pin_ff;
      lvl_in        = lvl_ff;
      used_in       = used_ff;
      stop_in       = stop_ff;
      scan_idx_in   = scan_idx_ff;
      issue_idx_in  = issue_idx_ff;
      cur_idx_in    = cur_idx_ff;
      cur_valid_in  = cur_valid_ff;
      nres_in       = nres_ff;
      hold_valid_in = hold_valid_ff;
      hold_kind_in  = hold_kind_ff;
      hold_id_in    = hold_id_ff;
      hold_pin_in   = hold_pin_ff;
      hold_lvl_in   = hold_lvl_ff;

      wr_en   = 1'b0;
      wr_addr = cur_idx_ff;
      wr_ent  = ent;
      rd_en   = 1'b0;
      rd_addr = issue_idx_ff[IDXW-1:0];

      push      = 1'b0;
      push_kind = KIND_DONE;
      push_data = '0;
      push_last = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in = req_tuser;
               now_in = req_tdata.now;
               ivl_in = req_tdata.interval;
               cnt_in = req_tdata.repeat_count;
               pin_in = req_tdata.pin;
               lvl_in = req_tdata.start_level;
               unique case (req_tuser)
                  CMD_ADD_CB, CMD_ADD_PIN: begin
                     scan_idx_in = '0;
                     state_in    = ST_ADD;
                  end
                  CMD_TICK: begin
                     issue_idx_in = '0;
                     cur_valid_in = 1'b0;
                     nres_in      = '0;
                     state_in     = ST_TICK;
                  end
                  CMD_STOP_ONE: begin
                     for (int i = 0; i < SLOTS; i++) begin
                        if (used_ff[i] && (32'(req_tdata.target_id) == 32'(i + 1))) begin
                           stop_in[i] = 1'b1;
                        end
                     end
                     state_in = ST_REPLY;
                  end
                  CMD_STOP_ALL: begin
                     stop_in  = stop_ff | used_ff;
                     state_in = ST_REPLY;
                  end
                  default: begin
                     state_in = ST_REPLY;
                  end
               endcase
            end
         end

         ST_ADD: begin
            if (scan_free || (scan_idx_ff == LAST_IDX)) begin
               if (out_ok) begin
                  push      = 1'b1;
                  push_last = 1'b1;
                  if (scan_free) begin
                     wr_en            = 1'b1;
                     wr_addr          = scan_idx_ff;
                     wr_ent.is_pin    = (cmd_ff == CMD_ADD_PIN);
                     wr_ent.start     = now_ff;
                     wr_ent.interval  = ivl_ff;
                     wr_ent.count     = cnt_ff;
                     wr_ent.pin       = (cmd_ff == CMD_ADD_PIN) ? pin_ff : '0;
                     wr_ent.level     = (cmd_ff == CMD_ADD_PIN) ? ~lvl_ff : 1'b0;
                     used_in[scan_idx_ff] = 1'b1;
                     stop_in[scan_idx_ff] = 1'b0;
                     push_data.event_id   = scan_id;
                     if (cmd_ff == CMD_ADD_PIN) begin
                        push_kind           = KIND_PIN;
                        push_data.pin_res   = pin_ff;
                        push_data.pin_level = ~lvl_ff;
                     end
                  end
                  state_in = ST_IDLE;
               end
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end

         ST_TICK: begin
            if (proceed) begin
               if (due) begin
                  wr_en          = 1'b1;
                  wr_ent.start   = ent.start + ent.interval;
                  wr_ent.count   = cnt_next;
                  wr_ent.level   = lvl_next;
                  stop_in[cur_idx_ff] = 1'b0;
                  if (cnt_next == '0) begin
                     used_in[cur_idx_ff] = 1'b0;
                  end
               end
               if (report) begin
                  if (hold_valid_ff) begin
                     push                = 1'b1;
                     push_kind           = hold_kind_ff;
                     push_data.event_id  = hold_id_ff;
                     push_data.pin_res   = hold_pin_ff;
                     push_data.pin_level = hold_lvl_ff;
                  end
                  hold_valid_in = 1'b1;
                  hold_id_in    = cur_id;
                  hold_kind_in  = ent.is_pin ? KIND_PIN : KIND_FIRE;
                  hold_pin_in   = ent.is_pin ? ent.pin : '0;
                  hold_lvl_in   = ent.is_pin ? lvl_next : 1'b0;
                  nres_in       = nres_ff + 1'b1;
               end
               if (cur_idx_ff == LAST_IDX) begin
                  state_in = ST_TICK_END;
               end
            end
            if (issue) begin
               rd_en        = 1'b1;
               issue_idx_in = issue_idx_ff + 1'b1;
               cur_idx_in   = issue_idx_ff[IDXW-1:0];
               cur_valid_in = 1'b1;
            end else if (proceed) begin
               cur_valid_in = 1'b0;
            end
         end

         ST_TICK_END: begin
            if (out_ok) begin
               push      = 1'b1;
               push_last = 1'b1;
               if (hold_valid_ff) begin
                  push_kind           = hold_kind_ff;
                  push_data.event_id  = hold_id_ff;
                  push_data.pin_res   = hold_pin_ff;
                  push_data.pin_level = hold_lvl_ff;
               end
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         ST_REPLY: begin
            if (out_ok) begin
               push      = 1'b1;
               push_last = 1'b1;
               state_in  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         stop_ff       <= '0;
         cur_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         stop_ff       <= stop_in;
         cur_valid_ff  <= cur_valid_in;
         hold_valid_ff <= hold_valid_in;
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload and walk counters
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      now_ff       <= now_in;
      ivl_ff       <= ivl_in;
      cnt_ff       <= cnt_in;
      pin_ff       <= pin_in;
      lvl_ff       <= lvl_in;
      scan_idx_ff  <= scan_idx_in;
      issue_idx_ff <= issue_idx_in;
      cur_idx_ff   <= cur_idx_in;
      nres_ff      <= nres_in;
      hold_kind_ff <= hold_kind_in;
      hold_id_ff   <= hold_id_in;
      hold_pin_ff  <= hold_pin_in;
      hold_lvl_ff  <= hold_lvl_in;
      if (push) begin
         rsp_kind_ff <= push_kind;
         rsp_data_ff <= push_data;
         rsp_last_ff <= push_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // the overlapped read never targets the slot being written back
   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("slot memory read and write hit the same entry");

   // a push never overwrites a result that has not been taken
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten");

   // fetched slot data only exists during a tick walk
   a_cur_in_tick: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (state_ff == ST_TICK))
      else $error("slot data valid outside tick walk");

   // a held fire is always flushed before the block goes idle
   a_hold_flushed: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> ((state_ff == ST_TICK) || (state_ff == ST_TICK_END)))
      else $error("held fire outside tick");

   // reported fires stay within the per-tick limit
   a_nres_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK) |-> (nres_ff <= NRES_MAX))
      else $error("too many fires reported");

endmodule
